>>> src/prsp_pkg.sv
// Shared types and constants for the page record stream parser.
// No dependencies; imported by prsp_outq and page_record_stream_parser.
`default_nettype none

package prsp_pkg;

    // Header lengths in bytes
    localparam int unsigned HDR_LEN     = 10;
    localparam int unsigned LNK_HDR_LEN = 12;
    localparam int unsigned HDR_BYTES   = 12;

    // Default depth of the result queue
    localparam int unsigned OUTQ_DEPTH = 4;

    // Result item kinds
    localparam logic [3:0] KIND_PAGE   = 4'd0;
    localparam logic [3:0] KIND_RUN    = 4'd1;
    localparam logic [3:0] KIND_IMAGE  = 4'd2;
    localparam logic [3:0] KIND_LINK   = 4'd3;
    localparam logic [3:0] KIND_TEXT   = 4'd4;
    localparam logic [3:0] KIND_HREF   = 4'd5;
    localparam logic [3:0] KIND_TARGET = 4'd6;
    localparam logic [3:0] KIND_FRAG   = 4'd7;
    localparam logic [3:0] KIND_STATUS = 4'd8;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_STALE = 1'b1;

    typedef enum logic [3:0] {
        PH_PAGE,
        PH_RUN_HDR,
        PH_RUN_TXT,
        PH_IMG_HDR,
        PH_IMG_HREF,
        PH_LNK_HDR,
        PH_LNK_TGT,
        PH_LNK_FRAG,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_byte_in;
        logic        end_of_blob;
        logic [15:0] page_number;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         kind;
        logic [15:0]        record_index;
        logic [31:0]        char_start;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        size_or_width;
        logic [15:0]        height;
        logic [7:0]         style_flags;
        logic [15:0]        length_a;
        logic [15:0]        length_b;
        logic [7:0]         string_byte;
        logic               status;
    } t_out_item;

    // Results of one accepted byte, handed to the queue
    typedef struct packed {
        logic [1:0] count;  // 0, 1 or 2 items
        t_out_item  first;
        t_out_item  second;
    } t_push;

    // Section bookkeeping after a record finishes
    typedef struct packed {
        t_phase      phase;
        logic [15:0] remaining;
        logic [15:0] index;
    } t_sect;

endpackage

`default_nettype wire

>>> src/prsp_outq.sv
// Result queue: register storage for up to two pushes and one pop per cycle.
// Depends on prsp_pkg (t_out_item, t_push).
`default_nettype none

module prsp_outq #(
    parameter int unsigned P_DEPTH = prsp_pkg::OUTQ_DEPTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  prsp_pkg::t_push       i_push,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire                   i_ready,
    output prsp_pkg::t_out_item   o_item
);
    import prsp_pkg::*;

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_out_item        r_mem [P_DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    w_wr1;
    logic             w_pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(P_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign w_pop   = o_valid && i_ready;
    assign w_wr1   = f_inc(r_wr);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    // room for the worst case of one byte
    assign o_space = (r_count <= CW'(P_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        if (i_push.count == 2'd1) begin
            n_wr = w_wr1;
        end else if (i_push.count == 2'd2) begin
            n_wr = f_inc(w_wr1);
        end
        if (w_pop) begin
            n_rd = f_inc(r_rd);
        end
        n_count = r_count + CW'(i_push.count) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr1] <= i_push.second;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("outq: count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |->
            ({1'b0, r_count} + (CW+1)'(i_push.count) <= (CW+1)'(P_DEPTH)))
        else $error("outq: push into full queue");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("outq: pop did not drain an item");

endmodule

`default_nettype wire

>>> src/page_record_stream_parser.sv
// Top level of the page record stream parser: byte parser state and result build.
// Depends on prsp_pkg and prsp_outq.
`default_nettype none

// Takes a serialized page record one byte per item and returns decoded items:
// one per completed page, run, image or link header, one per string byte, and
// an end status on the byte flagged end_of_blob (status 1 when the record was
// shorter than its headers and strings claim; earlier items of such a record
// are to be dropped by the consumer). Bytes after the parse completes are
// ignored, and the byte after end_of_blob starts a new record whose page
// number is sampled with its first byte. Rate: one byte per cycle. Each byte
// updates the parser registers in the cycle it is taken and its results are
// written into a P_OUTQ_DEPTH-entry result queue (default 4); results reach
// the output from its registers, in order. A byte that both completes an item
// and ends the record yields two results, which leave the queue one after
// the other. The input is ready while the queue has room for two results, so
// with the output always ready the block sustains one byte every cycle.

module page_record_stream_parser #(
    parameter int unsigned P_OUTQ_DEPTH = prsp_pkg::OUTQ_DEPTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  prsp_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output prsp_pkg::t_out_item   o_out_item
);
    import prsp_pkg::*;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    t_phase      r_phase, n_phase, s_phase;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt, s_hdr_cnt;
    logic [7:0]  r_hdr [HDR_BYTES];         // no reset: written before read
    logic [15:0] r_sect_rem, n_sect_rem, s_sect_rem;
    logic [15:0] r_sect_idx, n_sect_idx, s_sect_idx;
    logic [15:0] r_str_rem, n_str_rem, s_str_rem;
    logic [15:0] r_second_len, n_second_len, s_second_len;
    logic [15:0] r_img_total, n_img_total, s_img_total;
    logic [15:0] r_lnk_total, n_lnk_total, s_lnk_total;
    logic [15:0] r_page, n_page;

    logic        w_accept;
    logic        w_is_hdr;
    logic        w_hdr_done;
    logic [3:0]  w_need_m1;
    logic [7:0]  w_hdr_now [HDR_BYTES];
    logic [15:0] w_w [HDR_BYTES/2];
    logic [15:0] w_page_now;
    logic [15:0] w_str_dec;
    t_sect       w_fin;
    t_phase      w_fin_hdr;

    t_out_item   w_item;
    logic        w_item_valid;
    t_out_item   w_stat;
    t_push       w_push;

    assign w_accept = i_in_valid && o_in_ready;

    assign w_is_hdr = r_phase inside {PH_PAGE, PH_RUN_HDR, PH_IMG_HDR, PH_LNK_HDR};
    assign w_need_m1 = (r_phase == PH_LNK_HDR) ? 4'(LNK_HDR_LEN - 1) : 4'(HDR_LEN - 1);
    // counter never passes need-1 while in a header phase
    assign w_hdr_done = w_is_hdr && (r_hdr_cnt == w_need_m1);

    // page number is latched with the first byte of a record
    assign w_page_now = ((r_phase == PH_PAGE) && (r_hdr_cnt == 4'd0)) ?
                        i_in_item.page_number : r_page;

    // header view including the byte now arriving
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            w_hdr_now[i] = (r_hdr_cnt == 4'(i)) ? i_in_item.data_byte_in : r_hdr[i];
        end
        for (int k = 0; k < HDR_BYTES / 2; k++) begin
            w_w[k] = {w_hdr_now[2*k+1], w_hdr_now[2*k]};
        end
    end

    assign w_str_dec = r_str_rem - 16'd1;

    // Close out one record of a section; after its last record, move to the next non-empty section, or to done.
    function automatic t_sect f_finish(input t_phase hdr, input logic [15:0] rem,
                                       input logic [15:0] idx, input logic [15:0] img,
                                       input logic [15:0] lnk);
        t_sect       s;
        logic [15:0] rem1;
        rem1        = rem - 16'd1;
        s.index     = idx + 16'd1;
        s.remaining = rem1;
        s.phase     = hdr;
        if (rem1 == 16'd0) begin
            if (hdr == PH_RUN_HDR) begin
                s.index = '0;
                if (img != 16'd0) begin
                    s.remaining = img;
                    s.phase     = PH_IMG_HDR;
                end else begin
                    s.remaining = lnk;
                    s.phase     = (lnk != 16'd0) ? PH_LNK_HDR : PH_DONE;
                end
            end else if (hdr == PH_IMG_HDR) begin
                s.index     = '0;
                s.remaining = lnk;
                s.phase     = (lnk != 16'd0) ? PH_LNK_HDR : PH_DONE;
            end else begin
                s.phase = PH_DONE;
            end
        end
        return s;
    endfunction

    // which header phase a finishing record returns to
    always_comb begin
        case (r_phase)
            PH_RUN_HDR, PH_RUN_TXT:  w_fin_hdr = PH_RUN_HDR;
            PH_IMG_HDR, PH_IMG_HREF: w_fin_hdr = PH_IMG_HDR;
            default:                 w_fin_hdr = PH_LNK_HDR;
        endcase
    end

    assign w_fin = f_finish(w_fin_hdr, r_sect_rem, r_sect_idx, r_img_total, r_lnk_total);

    // ---------------------------------------------------------------
    // Next state: effect of one byte (s_*), then end-of-record restart
    // ---------------------------------------------------------------
    always_comb begin
        s_phase      = r_phase;
        s_hdr_cnt    = r_hdr_cnt;
        s_sect_rem   = r_sect_rem;
        s_sect_idx   = r_sect_idx;
        s_str_rem    = r_str_rem;
        s_second_len = r_second_len;
        s_img_total  = r_img_total;
        s_lnk_total  = r_lnk_total;

        case (r_phase)
            PH_PAGE, PH_RUN_HDR, PH_IMG_HDR, PH_LNK_HDR: begin
                if (!w_hdr_done) begin
                    s_hdr_cnt = r_hdr_cnt + 4'd1;
                end else begin
                    s_hdr_cnt = '0;
                    case (r_phase)
                        PH_PAGE: begin
                            s_img_total = w_w[3];
                            s_lnk_total = w_w[4];
                            s_sect_idx  = '0;
                            if (w_w[2] != 16'd0) begin
                                s_sect_rem = w_w[2];
                                s_phase    = PH_RUN_HDR;
                            end else if (w_w[3] != 16'd0) begin
                                s_sect_rem = w_w[3];
                                s_phase    = PH_IMG_HDR;
                            end else begin
                                s_sect_rem = w_w[4];
                                s_phase    = (w_w[4] != 16'd0) ? PH_LNK_HDR : PH_DONE;
                            end
                        end
                        PH_RUN_HDR, PH_IMG_HDR: begin
                            s_str_rem = w_w[4];
                            if (w_w[4] != 16'd0) begin
                                s_phase = (r_phase == PH_RUN_HDR) ? PH_RUN_TXT : PH_IMG_HREF;
                            end else begin
                                s_phase    = w_fin.phase;
                                s_sect_rem = w_fin.remaining;
                                s_sect_idx = w_fin.index;
                            end
                        end
                        default: begin
                            s_str_rem    = w_w[4];
                            s_second_len = w_w[5];
                            if (w_w[4] != 16'd0) begin
                                s_phase = PH_LNK_TGT;
                            end else if (w_w[5] != 16'd0) begin
                                s_str_rem = w_w[5];
                                s_phase   = PH_LNK_FRAG;
                            end else begin
                                s_phase    = w_fin.phase;
                                s_sect_rem = w_fin.remaining;
                                s_sect_idx = w_fin.index;
                            end
                        end
                    endcase
                end
            end
            PH_RUN_TXT, PH_IMG_HREF, PH_LNK_TGT, PH_LNK_FRAG: begin
                s_str_rem = w_str_dec;
                if (w_str_dec == 16'd0) begin
                    if ((r_phase == PH_LNK_TGT) && (r_second_len != 16'd0)) begin
                        s_str_rem = r_second_len;
                        s_phase   = PH_LNK_FRAG;
                    end else begin
                        s_phase    = w_fin.phase;
                        s_sect_rem = w_fin.remaining;
                        s_sect_idx = w_fin.index;
                    end
                end
            end
            default: begin
                // parse complete: trailing bytes change nothing
            end
        endcase

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_sect_rem   = r_sect_rem;
        n_sect_idx   = r_sect_idx;
        n_str_rem    = r_str_rem;
        n_second_len = r_second_len;
        n_img_total  = r_img_total;
        n_lnk_total  = r_lnk_total;
        n_page       = r_page;
        if (w_accept) begin
            if (i_in_item.end_of_blob) begin
                n_phase      = PH_PAGE;
                n_hdr_cnt    = '0;
                n_sect_rem   = '0;
                n_sect_idx   = '0;
                n_str_rem    = '0;
                n_second_len = '0;
                n_img_total  = '0;
                n_lnk_total  = '0;
                n_page       = '0;
            end else begin
                n_phase      = s_phase;
                n_hdr_cnt    = s_hdr_cnt;
                n_sect_rem   = s_sect_rem;
                n_sect_idx   = s_sect_idx;
                n_str_rem    = s_str_rem;
                n_second_len = s_second_len;
                n_img_total  = s_img_total;
                n_lnk_total  = s_lnk_total;
                n_page       = w_page_now;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result items for this byte
    // ---------------------------------------------------------------
    always_comb begin
        w_item              = '0;
        w_item_valid        = 1'b0;
        w_item.record_index = r_sect_idx;
        case (r_phase)
            PH_PAGE: begin
                w_item_valid        = w_hdr_done;
                w_item.kind         = KIND_PAGE;
                w_item.record_index = w_page_now;
                w_item.char_start   = {w_w[1], w_w[0]};
                w_item.length_a     = w_w[2];
                w_item.length_b     = w_w[3];
                w_item.height       = w_w[4];
            end
            PH_RUN_HDR: begin
                w_item_valid         = w_hdr_done;
                w_item.kind          = KIND_RUN;
                w_item.pos_x         = $signed(w_w[0]);
                w_item.pos_y         = $signed(w_w[1]);
                w_item.size_or_width = w_w[2];
                w_item.style_flags   = w_hdr_now[6];
                w_item.length_a      = w_w[4];
            end
            PH_IMG_HDR, PH_LNK_HDR: begin
                w_item_valid         = w_hdr_done;
                w_item.kind          = (r_phase == PH_IMG_HDR) ? KIND_IMAGE : KIND_LINK;
                w_item.pos_x         = $signed(w_w[0]);
                w_item.pos_y         = $signed(w_w[1]);
                w_item.size_or_width = w_w[2];
                w_item.height        = w_w[3];
                w_item.length_a      = w_w[4];
                w_item.length_b      = (r_phase == PH_LNK_HDR) ? w_w[5] : 16'd0;
            end
            PH_RUN_TXT: begin
                w_item_valid       = 1'b1;
                w_item.kind        = KIND_TEXT;
                w_item.string_byte = i_in_item.data_byte_in;
            end
            PH_IMG_HREF: begin
                w_item_valid       = 1'b1;
                w_item.kind        = KIND_HREF;
                w_item.string_byte = i_in_item.data_byte_in;
            end
            PH_LNK_TGT: begin
                w_item_valid       = 1'b1;
                w_item.kind        = KIND_TARGET;
                w_item.string_byte = i_in_item.data_byte_in;
            end
            PH_LNK_FRAG: begin
                w_item_valid       = 1'b1;
                w_item.kind        = KIND_FRAG;
                w_item.string_byte = i_in_item.data_byte_in;
            end
            default: begin
                w_item_valid = 1'b0;
            end
        endcase

        w_stat              = '0;
        w_stat.kind         = KIND_STATUS;
        w_stat.record_index = w_page_now;
        w_stat.status       = (s_phase == PH_DONE) ? STATUS_OK : STATUS_STALE;

        w_push        = '0;
        w_push.second = w_stat;
        w_push.first  = w_item_valid ? w_item : w_stat;
        if (w_accept) begin
            w_push.count = 2'(w_item_valid) + 2'(i_in_item.end_of_blob);
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PAGE;
            r_hdr_cnt    <= '0;
            r_sect_rem   <= '0;
            r_sect_idx   <= '0;
            r_str_rem    <= '0;
            r_second_len <= '0;
            r_img_total  <= '0;
            r_lnk_total  <= '0;
            r_page       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_sect_rem   <= n_sect_rem;
            r_sect_idx   <= n_sect_idx;
            r_str_rem    <= n_str_rem;
            r_second_len <= n_second_len;
            r_img_total  <= n_img_total;
            r_lnk_total  <= n_lnk_total;
            r_page       <= n_page;
        end
    end

    // header byte capture
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (w_accept && w_is_hdr && (r_hdr_cnt == 4'(i))) begin
                r_hdr[i] <= i_in_item.data_byte_in;
            end
        end
    end

    prsp_outq #(
        .P_DEPTH (P_OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_cnt_only_in_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_is_hdr |-> (r_hdr_cnt == 4'd0))
        else $error("header count left over outside a header phase");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_hdr |-> (r_hdr_cnt <= w_need_m1))
        else $error("header count past header length");

    a_str_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_RUN_TXT) || (r_phase == PH_IMG_HREF) ||
         (r_phase == PH_LNK_TGT) || (r_phase == PH_LNK_FRAG)) |-> (r_str_rem != 16'd0))
        else $error("string phase with nothing left");

    a_eob_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.end_of_blob) |=> ((r_phase == PH_PAGE) && (r_hdr_cnt == 4'd0)))
        else $error("end of record did not restart the parser");

endmodule

`default_nettype wire
